// ----- hw/rtl/tmwem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmwem_pkg;

  localparam int unsigned DEF_MAX_ROWS = 256;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned ROW_W        = 8;
  localparam int unsigned ID_W         = 19;
  localparam int unsigned COORD_W      = 11;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned NUM_SLOTS    = 6;
  localparam int unsigned SLOT_IDX_W   = 3;
  localparam int unsigned CMD_DEPTH    = 4;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 64;

  localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 9'd32;
  localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 9'd32;

  // configuration register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // event slots of one tile, in emission order
  localparam logic [SLOT_IDX_W-1:0] SLOT_N  = 3'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_E0 = 3'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_E1 = 3'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_S  = 3'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_W0 = 3'd4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_W1 = 3'd5;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_EXTEND = 1'b1;

  // y offset from the tile center, quarter tiles
  typedef enum logic [1:0] {
    DY_M2,
    DY_M1,
    DY_P2
  } dy_e;

  typedef struct packed {
    logic southwest_wall;
    logic southeast_wall;
    logic west_wall;
    logic south_wall;
    logic east_wall;
    logic north_wall;
    logic is_wall;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tile_t;

  typedef struct packed {
    logic vld;
    logic [ID_W-1:0] id;
  } line_t;

  typedef struct packed {
    line_t north;
    line_t south;
  } line_pair_t;

  typedef struct packed {
    logic vld;
    logic face;
    logic [ID_W-1:0] id;
  } prev_t;

  typedef struct packed {
    logic vld;
    logic ext;
    logic face;
    dy_e  sdy;
    dy_e  edy;
  } slot_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [ID_W-1:0] base_id;
    slot_t [NUM_SLOTS-1:0] slots;
    logic [3:0][ID_W-1:0] ext_id;
  } tile_cmd_t;

  typedef struct packed {
    logic kind;
    logic [ID_W-1:0] id;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic face;
    logic last;
  } edge_ev_t;

  typedef struct packed {
    slot_t s0;
    slot_t s1;
    logic [1:0] ins;
    prev_t nxt;
    logic [ID_W-1:0] ext_id;
  } side_plan_t;

  function automatic slot_t mk_slot(logic ext, logic face, dy_e sdy, dy_e edy);
    slot_t s;
    s.vld  = 1'b1;
    s.ext  = ext;
    s.face = face;
    s.sdy  = sdy;
    s.edy  = edy;
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] dy_val(dy_e dy);
    logic [COORD_W-1:0] v;
    case (dy)
      DY_M2:   v = -COORD_W'(2);
      DY_M1:   v = -COORD_W'(1);
      DY_P2:   v = COORD_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // East or west side of a wall tile. id0/id1 are the next two free ids.
  function automatic side_plan_t side_plan(prev_t prev, logic blocked, logic border,
                                           logic diag, logic top_row, logic last_row,
                                           logic below, logic [ID_W-1:0] id0,
                                           logic [ID_W-1:0] id1);
    side_plan_t p;
    logic split;
    p        = '0;
    split    = ~last_row & ~below;
    p.ext_id = prev.id;
    if (blocked) begin
      // plain lower part beside a wall, kept open for the tile below
      if (!border && !last_row && !diag && below) begin
        p.s0       = mk_slot(1'b0, 1'b0, DY_M1, DY_P2);
        p.ins      = 2'd1;
        p.nxt.vld  = 1'b1;
        p.nxt.id   = id0;
      end
    end else if (top_row) begin
      p.s0      = mk_slot(1'b0, 1'b0, DY_M2, DY_P2);
      p.ins     = 2'd1;
      p.nxt.vld = 1'b1;
      p.nxt.id  = id0;
    end else if (prev.vld && !prev.face) begin
      if (split) begin
        p.s0       = mk_slot(1'b1, 1'b0, DY_M2, DY_M1);
        p.s1       = mk_slot(1'b0, 1'b1, DY_M1, DY_P2);
        p.ins      = 2'd1;
        p.nxt.vld  = 1'b1;
        p.nxt.face = 1'b1;
        p.nxt.id   = id0;
      end else begin
        p.s0      = mk_slot(1'b1, 1'b0, DY_M2, DY_P2);
        p.nxt.vld = 1'b1;
        p.nxt.id  = prev.id;
      end
    end else if (split) begin
      p.s0       = mk_slot(1'b0, 1'b0, DY_M2, DY_M1);
      p.s1       = mk_slot(1'b0, 1'b1, DY_M1, DY_P2);
      p.ins      = 2'd2;
      p.nxt.vld  = 1'b1;
      p.nxt.face = 1'b1;
      p.nxt.id   = id1;
    end else begin
      p.s0      = mk_slot(1'b0, 1'b0, DY_M2, DY_P2);
      p.ins     = 2'd1;
      p.nxt.vld = 1'b1;
      p.nxt.id  = id0;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tile_map_wall_edge_merger.sv -----
// Tile map wall edge merger.
// Slave stream: one map tile per request, columns outer, rows inner. Master
// stream: edge events, one per request; tlast marks the final event of a tile,
// tuser is the event kind (insert or extend). Tiles that make no event give
// no request on the master side.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 map
// width, 1 map height) at the clock edge; write only while the block is idle.
// The first event of a tile passes the front's tile register, the command
// queue and the event register. The front takes one tile per cycle while the
// queue has room (line store read, then classify and write back); the back
// drives one event per cycle from a four-entry command queue while the master
// side takes them. A master-side stall holds the event register, then fills the
// queue, then drops s_axis_tready; nothing is lost.
// Reset clears the open side edges, the id counter and all queues; the line
// store needs no clearing since its contents are ignored in the first column.
`timescale 1ns / 1ps
`default_nettype none

module tile_map_wall_edge_merger import tmwem_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // cfg
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  // tiles in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // col, row, is_wall, north_wall, east_wall, south_wall, west_wall,
  // southeast_wall, southwest_wall, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // events out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // edge_id, start_x, start_y, end_x, end_y, is_face
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // event_kind
  output logic [0:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  tile_t     tile;
  tile_cmd_t push_cmd, head_cmd;
  logic      push, full, head_valid, pop;
  edge_ev_t  ev;

  assign tile = tile_t'(s_axis_tdata[$bits(tile_t)-1:0]);

  tmwem_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .tile_valid_i (s_axis_tvalid),
    .tile_ready_o (s_axis_tready),
    .tile_i       (tile),
    .cmd_push_o   (push),
    .cmd_o        (push_cmd),
    .cmd_full_i   (full)
  );

  tmwem_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  tmwem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .ev_valid_o  (m_axis_tvalid),
    .ev_ready_i  (m_axis_tready),
    .ev_o        (ev)
  );

  assign m_axis_tdata = {ev.face, ev.ey, ev.ex, ev.sy, ev.sx, ev.id};
  assign m_axis_tuser = ev.kind;
  assign m_axis_tlast = ev.last;

endmodule

`default_nettype wire

// ----- hw/rtl/tmwem_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmwem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tmwem_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmwem_front import tmwem_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  localparam int unsigned RI_W    = $clog2(MAX_ROWS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             tile_valid_i,
  output logic                  tile_ready_o,
  input  wire tile_t            tile_i,
  output logic                  cmd_push_o,
  output tile_cmd_t             cmd_o,
  input  wire logic             cmd_full_i
);

  localparam int unsigned ROW_VALUES = 1 << ROW_W;

  logic [CFG_W-1:0] map_width_q, map_height_q;
  logic             s1_valid_q, s1_valid_d;
  tile_t            s1_tile_q;
  logic [RI_W-1:0]  ri_q;
  logic             hit_q;
  line_pair_t       byp_q;
  prev_t            east_prev_q, west_prev_q, east_prev_d, west_prev_d;
  logic [ID_W-1:0]  next_id_q, next_id_d;

  logic [RI_W-1:0]  row_idx [ROW_VALUES];
  logic [RI_W-1:0]  ri_new;
  logic             accept, s1_fire;
  line_pair_t       ram_rdata, lines, wdata;

  logic             top_row, first_col, last_col, last_row;
  logic [ID_W-1:0]  base;
  logic [ID_W-1:0]  ids [NUM_SLOTS+1];
  logic [2:0]       off_e, off_s, off_w, off_end;
  logic             n_ins, s_ins;
  slot_t            n_slot, s_slot;
  side_plan_t       ep, wp;
  line_t            n_line_d, s_line_d;
  tile_cmd_t        cmd;
  logic             any_ev;

  // line store row index, row modulo depth, as a constant table
  for (genvar g = 0; g < ROW_VALUES; g++) begin : g_row_idx
    assign row_idx[g] = RI_W'(g % MAX_ROWS);
  end

  assign ri_new       = row_idx[tile_i.row];
  assign tile_ready_o = !s1_valid_q || s1_fire;
  assign accept       = tile_valid_i && tile_ready_o;
  assign s1_fire      = s1_valid_q && !(cmd_push_o && cmd_full_i);

  tmwem_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_ROWS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (ri_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (ri_new),
    .rdata_o (ram_rdata)
  );

  // a write to the row just read lands too late for the RAM port, so it is bypassed
  assign lines = hit_q ? byp_q : ram_rdata;

  always_comb begin
    top_row   = (s1_tile_q.row == '0);
    first_col = (s1_tile_q.col == '0);
    last_col  = ({1'b0, s1_tile_q.col} + CFG_W'(1)) >= map_width_q;
    last_row  = ({1'b0, s1_tile_q.row} + CFG_W'(1)) >= map_height_q;
    base      = (first_col && top_row) ? '0 : next_id_q;
    for (int k = 0; k <= NUM_SLOTS; k++) begin
      ids[k] = base + ID_W'(k);
    end

    // north
    n_slot   = '0;
    n_ins    = 1'b0;
    n_line_d = lines.north;
    if (top_row || s1_tile_q.north_wall) begin
      n_line_d = '0;
    end else if (!first_col && lines.north.vld) begin
      n_slot = mk_slot(1'b1, 1'b0, DY_M2, DY_M2);
    end else begin
      n_slot       = mk_slot(1'b0, 1'b0, DY_M2, DY_M2);
      n_ins        = 1'b1;
      n_line_d.vld = 1'b1;
      n_line_d.id  = ids[0];
    end
    off_e = {2'b00, n_ins};

    ep = side_plan(east_prev_q, last_col | s1_tile_q.east_wall, last_col,
                   s1_tile_q.southeast_wall, top_row, last_row, s1_tile_q.south_wall,
                   ids[off_e], ids[off_e + 3'd1]);
    off_s = off_e + {1'b0, ep.ins};

    // south
    s_slot   = '0;
    s_ins    = 1'b0;
    s_line_d = lines.south;
    if (last_row || s1_tile_q.south_wall) begin
      s_line_d = '0;
    end else if (!first_col && lines.south.vld) begin
      s_slot = mk_slot(1'b1, 1'b0, DY_M1, DY_M1);
    end else begin
      s_slot       = mk_slot(1'b0, 1'b0, DY_M1, DY_M1);
      s_ins        = 1'b1;
      s_line_d.vld = 1'b1;
      s_line_d.id  = ids[off_s];
    end
    off_w = off_s + {2'b00, s_ins};

    wp = side_plan(west_prev_q, first_col | s1_tile_q.west_wall, first_col,
                   s1_tile_q.southwest_wall, top_row, last_row, s1_tile_q.south_wall,
                   ids[off_w], ids[off_w + 3'd1]);
    off_end = off_w + {1'b0, wp.ins};

    cmd.col     = s1_tile_q.col;
    cmd.row     = s1_tile_q.row;
    cmd.base_id = base;
    cmd.slots[SLOT_N]  = n_slot;
    cmd.slots[SLOT_E0] = ep.s0;
    cmd.slots[SLOT_E1] = ep.s1;
    cmd.slots[SLOT_S]  = s_slot;
    cmd.slots[SLOT_W0] = wp.s0;
    cmd.slots[SLOT_W1] = wp.s1;
    cmd.ext_id[SIDE_N] = lines.north.id;
    cmd.ext_id[SIDE_E] = ep.ext_id;
    cmd.ext_id[SIDE_S] = lines.south.id;
    cmd.ext_id[SIDE_W] = wp.ext_id;

    any_ev = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      any_ev = any_ev | cmd.slots[i].vld;
    end

    if (s1_tile_q.is_wall) begin
      wdata.north = n_line_d;
      wdata.south = s_line_d;
      east_prev_d = ep.nxt;
      west_prev_d = wp.nxt;
      next_id_d   = ids[off_end];
    end else begin
      // floor tile closes every open edge around it
      wdata       = '0;
      east_prev_d = '0;
      west_prev_d = '0;
      next_id_d   = base;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = s1_valid_q && s1_tile_q.is_wall && any_ev;
  assign s1_valid_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      s1_valid_q   <= 1'b0;
      hit_q        <= 1'b0;
      east_prev_q  <= '0;
      west_prev_q  <= '0;
      next_id_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
          REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        hit_q <= s1_fire && (ri_q == ri_new);
      end
      if (s1_fire) begin
        east_prev_q <= east_prev_d;
        west_prev_q <= west_prev_d;
        next_id_q   <= next_id_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tile_q <= tile_i;
      ri_q      <= ri_new;
      byp_q     <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmwem_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmwem_fifo import tmwem_pkg::*; #(
  parameter int unsigned DEPTH = CMD_DEPTH,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire tile_cmd_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output tile_cmd_t      data_o
);

  tile_cmd_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmwem_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmwem_back import tmwem_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire tile_cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           ev_valid_o,
  input  wire logic      ev_ready_i,
  output edge_ev_t       ev_o
);

  logic                   started_q;
  logic [NUM_SLOTS-1:0]   rem_q;
  logic [ID_W-1:0]        id_q;
  logic                   out_valid_q;
  edge_ev_t               out_q;

  logic [NUM_SLOTS-1:0]   vld_mask, rem, rem_next;
  logic [SLOT_IDX_W-1:0]  k;
  logic [1:0]             side;
  slot_t                  slot;
  logic [ID_W-1:0]        id_cur, id_next;
  logic [COORD_W-1:0]     x4, y4, xm2, xp2;
  logic                   emit;
  edge_ev_t               ev;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      vld_mask[i] = cmd_i.slots[i].vld;
    end
    rem    = started_q ? rem_q : vld_mask;
    id_cur = started_q ? id_q : cmd_i.base_id;

    // lowest pending slot
    k = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        k = SLOT_IDX_W'(i);
      end
    end
    rem_next = rem & ~(NUM_SLOTS'(1) << k);
    slot     = cmd_i.slots[k];

    case (k)
      SLOT_N:           side = SIDE_N;
      SLOT_E0, SLOT_E1: side = SIDE_E;
      SLOT_S:           side = SIDE_S;
      default:          side = SIDE_W;
    endcase

    x4  = {1'b0, cmd_i.col, 2'b00};
    y4  = {1'b0, cmd_i.row, 2'b00};
    xm2 = x4 - COORD_W'(2);
    xp2 = x4 + COORD_W'(2);

    ev.kind = slot.ext ? KIND_EXTEND : KIND_INSERT;
    ev.id   = slot.ext ? cmd_i.ext_id[side] : id_cur;
    case (side)
      SIDE_E:  begin ev.sx = xp2; ev.ex = xp2; end
      SIDE_W:  begin ev.sx = xm2; ev.ex = xm2; end
      default: begin ev.sx = xm2; ev.ex = xp2; end
    endcase
    ev.sy   = y4 + dy_val(slot.sdy);
    ev.ey   = y4 + dy_val(slot.edy);
    ev.face = slot.face & ~slot.ext;
    ev.last = (rem_next == '0);
    if (slot.ext) begin
      ev.sx = '0;
      ev.sy = '0;
    end
    id_next = slot.ext ? id_cur : id_cur + ID_W'(1);
  end

  assign emit       = cmd_valid_i && (!out_valid_q || ev_ready_i);
  assign cmd_pop_o  = emit && ev.last;
  assign ev_valid_o = out_valid_q;
  assign ev_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      rem_q       <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        started_q   <= !ev.last;
        rem_q       <= rem_next;
        id_q        <= id_next;
      end else if (ev_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= ev;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmwem_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmwem_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled event stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("event changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("event valid during reset");

  // extends carry only the new end point
  a_extend_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[29:19] == 11'd0
      && m_axis_tdata[40:30] == 11'd0 && !m_axis_tdata[63])
    else $error("extend event with start point or face flag");

  // inserted edges are horizontal or vertical, face edges vertical
  a_insert_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[29:19] == m_axis_tdata[51:41])
      || (!m_axis_tdata[63] && m_axis_tdata[40:30] == m_axis_tdata[62:52]))
    else $error("inserted edge not axis aligned");

endmodule

bind tile_map_wall_edge_merger tmwem_checker u_tmwem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
